// ----- sv/tcre_pkg.sv -----
// Package for the TCP connection receive engine.
// Holds state codes, flag bits, command codes and the reorder entry type.
// No dependencies.
package tcre_pkg;

	localparam int DefReorderDepth = 8;
	localparam int MaxDeliver = 8;

	localparam logic [3:0] ST_CLOSED    = 4'd0;
	localparam logic [3:0] ST_LISTEN    = 4'd1;
	localparam logic [3:0] ST_SYN_SENT  = 4'd2;
	localparam logic [3:0] ST_SYN_RCVD  = 4'd3;
	localparam logic [3:0] ST_ESTAB     = 4'd4;
	localparam logic [3:0] ST_FINW1     = 4'd5;
	localparam logic [3:0] ST_FINW2     = 4'd6;
	localparam logic [3:0] ST_CLOSING   = 4'd7;
	localparam logic [3:0] ST_TIMEWAIT  = 4'd8;
	localparam logic [3:0] ST_CLOSEWAIT = 4'd9;

	localparam logic [5:0] FL_FIN = 6'd1;
	localparam logic [5:0] FL_SYN = 6'd2;
	localparam logic [5:0] FL_RST = 6'd4;
	localparam logic [5:0] FL_ACK = 6'd16;

	localparam logic [1:0] FN_SEGMENT = 2'd0;
	localparam logic [1:0] FN_PASSIVE = 2'd1;
	localparam logic [1:0] FN_ACTIVE  = 2'd2;
	localparam logic [1:0] FN_SEND    = 2'd3;

	localparam logic CFG_ISS = 1'b0;
	localparam logic CFG_WIN = 1'b1;

	localparam logic KIND_HDR = 1'b0;
	localparam logic KIND_DLV = 1'b1;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] len;
	} ent_t;

endpackage

// ----- sv/tcre_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tcre_ram #(
	parameter int Width = 8,
	parameter int Depth = 8,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tcre_cmp.sv -----
// Shared 32-bit sequence comparator: unsigned less-than and equality.
// No dependencies.
module tcre_cmp (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        lt,
	output logic        eq
);

	assign lt = a < b;
	assign eq = a == b;

endmodule

// ----- sv/tcp_connection_receive_engine_top.sv -----
// Top level of the single-connection TCP receive engine.
// Depends on tcre_pkg, tcre_ram and tcre_cmp.
//
// Usage:
//   Command channel: an item (func, seg_flags, seg_seq, seg_ack, seg_window,
//   payload_length) is taken when start is high and busy is low. busy drops
//   in the cycle after the sequencer issues the final result of the item.
//   Result channel: each result is shown for one cycle with strobe high;
//   last marks the final result of an item. Results pass one output register,
//   so the final result shows in the first cycle with busy low. The receiver
//   cannot stall, so results go out as the sequencer produces them. Items
//   may produce none.
//   Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; index 0 is
//   the initial send sequence (also loads the send pointer), index 1 the
//   advertised window. cfg_ready follows !busy; write only when idle.
// Sequence: latch the item, then decide (emits any header: handshake, RST
//   or send); for data segments, insertion compares into the sorted reorder
//   ring (skipped when the ring is full), up to MaxDeliver in-order
//   deliveries, each a table read and a compare, plus the final check, then
//   the ACK and, for a FIN, a FIN ACK. The single table RAM read port and the
//   shared comparator serialise these steps.
// Reset: connection closed, all pointers zero, reorder table empty.
module tcp_connection_receive_engine_top
	import tcre_pkg::*;
#(
	parameter int REORDER_DEPTH = DefReorderDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [5:0]  seg_flags,
	input  logic [31:0] seg_seq,
	input  logic [31:0] seg_ack,
	input  logic [15:0] seg_window,
	input  logic [15:0] payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output logic        kind,
	output logic [31:0] out_seq,
	output logic [31:0] out_ack,
	output logic [5:0]  out_flags,
	output logic [15:0] out_window,
	output logic [15:0] out_length,
	output logic [3:0]  conn_state_now,
	output logic        last
);

	localparam int AW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
	localparam int CW = $clog2(REORDER_DEPTH + 1);
	localparam int EW = $bits(ent_t);

	// sequencer codes
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECIDE  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_INS_NEW = 3'd3;
	localparam logic [2:0] S_DLV_REQ = 3'd4;
	localparam logic [2:0] S_DLV_CMP = 3'd5;
	localparam logic [2:0] S_ACK     = 3'd6;
	localparam logic [2:0] S_FIN     = 3'd7;

	// ring address of logical slot i
	function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [AW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, h} + {1'b0, i};
		if (s >= (AW+1)'(REORDER_DEPTH)) begin
			s = s - (AW+1)'(REORDER_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	logic [2:0]  sq_q;
	logic [1:0]  fn_q;
	logic [5:0]  fl_q;
	logic [31:0] seq_q, ack_q;
	logic [15:0] win_q, len_q;
	logic [31:0] iss_q, snxt_q, suna_q, wus_q, wua_q, rnxt_q;
	logic [15:0] adv_q;
	logic [3:0]  cs_q;
	logic        fin_q;
	logic [AW-1:0] head_q, k_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]  dn_q;

	// decide outputs
	logic [3:0]  n_cs;
	logic [31:0] n_snxt, n_suna, n_wus, n_wua, n_rnxt;
	logic        h_v;
	logic [31:0] h_seq;
	logic [5:0]  h_flags;
	logic [15:0] h_len;
	logic        dd, df;
	logic [3:0]  st1;
	logic        in_rng, bad;

	// table and comparator
	logic          we;
	logic [AW-1:0] waddr, raddr;
	ent_t          wdata, rdata;
	logic [31:0]   ca, cb;
	logic          c_lt, c_eq;

	// emit
	logic        e_v, e_kind, e_last;
	logic [31:0] e_seq, e_ack;
	logic [5:0]  e_flags;
	logic [15:0] e_len;

	tcre_ram #(.Width(EW), .Depth(REORDER_DEPTH)) u_tab (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	tcre_cmp u_cmp (.a(ca), .b(cb), .lt(c_lt), .eq(c_eq));

	assign busy = sq_q != S_IDLE;
	assign cfg_ready = !busy;

	// connection decision on the latched item
	always_comb begin
		n_cs = cs_q; n_snxt = snxt_q; n_suna = suna_q;
		n_wus = wus_q; n_wua = wua_q; n_rnxt = rnxt_q;
		h_v = 1'b0; h_seq = snxt_q; h_flags = FL_ACK; h_len = '0;
		dd = 1'b0; df = 1'b0; st1 = cs_q;
		in_rng = (suna_q <= ack_q) && (ack_q <= snxt_q);
		bad = ((fl_q & FL_ACK) != 0) && ((ack_q <= iss_q) || (ack_q > snxt_q));
		case (fn_q)
			FN_PASSIVE: n_cs = ST_LISTEN;
			FN_ACTIVE: begin
				n_cs = ST_SYN_SENT; h_v = 1'b1; h_flags = FL_SYN;
				n_snxt = snxt_q + 32'd1;
			end
			FN_SEND: begin
				h_v = 1'b1; h_len = len_q;
				n_snxt = snxt_q + {16'd0, len_q};
			end
			default: begin
				if (cs_q == ST_LISTEN) begin
					if ((fl_q & FL_SYN) != 0 && (fl_q & FL_ACK) == 0) begin
						n_rnxt = seq_q + 32'd1; n_suna = ack_q;
						n_wus = seq_q; n_wua = ack_q; n_cs = ST_SYN_RCVD;
						h_v = 1'b1; h_flags = FL_SYN | FL_ACK;
						n_snxt = snxt_q + 32'd1;
					end
				end else if (cs_q == ST_SYN_SENT) begin
					if (!bad && (fl_q & FL_SYN) != 0) begin
						n_rnxt = seq_q + 32'd1; h_v = 1'b1;
						if ((fl_q & FL_ACK) != 0) begin
							n_suna = ack_q; n_wus = seq_q; n_wua = ack_q;
							n_cs = ST_ESTAB;
						end else begin
							n_cs = ST_SYN_RCVD; h_seq = snxt_q - 32'd1;
							h_flags = FL_SYN | FL_ACK;
						end
					end
				end else if ((fl_q & FL_RST) == 0) begin
					if ((fl_q & FL_SYN) != 0) begin
						h_v = 1'b1; h_seq = '0; h_flags = FL_RST | FL_ACK;
					end else if ((fl_q & FL_ACK) != 0) begin
						if (cs_q == ST_SYN_RCVD) begin
							if (in_rng) begin
								n_wus = seq_q; n_wua = ack_q; st1 = ST_ESTAB;
							end else begin
								h_v = 1'b1; h_seq = ack_q; h_flags = FL_RST | FL_ACK;
							end
						end else if (cs_q == ST_ESTAB && in_rng) begin
							n_suna = ack_q;
							if (wus_q < seq_q || (wus_q == seq_q && wua_q < ack_q)) begin
								n_wus = seq_q; n_wua = ack_q;
							end
						end
						dd = (len_q != 16'd0) && (st1 == ST_ESTAB);
						df = (fl_q & FL_FIN) != 0;
						n_cs = st1;
						if (df) begin
							case (st1)
								ST_SYN_RCVD, ST_ESTAB: n_cs = ST_CLOSEWAIT;
								ST_FINW1: n_cs = (ack_q > snxt_q) ? ST_TIMEWAIT : ST_CLOSING;
								ST_FINW2, ST_TIMEWAIT: n_cs = ST_TIMEWAIT;
								default: n_cs = st1;
							endcase
						end
					end
				end
			end
		endcase
	end

	// table walk, comparator steering and result selection
	always_comb begin
		we = 1'b0; waddr = ring(head_q, k_q + AW'(1));
		wdata.seq = seq_q; wdata.len = len_q;
		raddr = head_q;
		ca = seq_q; cb = rdata.seq;
		e_v = 1'b0; e_kind = KIND_HDR; e_last = 1'b0;
		e_seq = snxt_q; e_flags = FL_ACK; e_len = '0;
		e_ack = rnxt_q;
		case (sq_q)
			S_DECIDE: begin
				raddr = ring(head_q, AW'(cnt_q - CW'(1)));
				e_v = h_v; e_seq = h_seq; e_flags = h_flags; e_len = h_len;
				e_ack = ((h_flags & FL_ACK) != 0) ? n_rnxt : 32'd0;
				e_last = !(dd || df);
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (c_lt) begin
					wdata = rdata;
					raddr = ring(head_q, k_q - AW'(1));
				end
			end
			S_INS_NEW: begin
				we = 1'b1; waddr = head_q;
			end
			S_DLV_CMP: begin
				ca = rnxt_q;
				if (c_eq) begin
					e_v = 1'b1; e_kind = KIND_DLV; e_seq = rdata.seq;
					e_ack = '0; e_flags = '0; e_len = rdata.len;
				end
			end
			S_ACK: begin
				e_v = 1'b1; e_last = !fin_q;
			end
			S_FIN: begin
				e_v = 1'b1; e_last = 1'b1; e_ack = seq_q + 32'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= S_IDLE; cs_q <= ST_CLOSED;
			iss_q <= '0; snxt_q <= '0; adv_q <= 16'hFFFF;
			suna_q <= '0; wus_q <= '0; wua_q <= '0; rnxt_q <= '0;
			head_q <= '0; cnt_q <= '0; k_q <= '0; dn_q <= '0; fin_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ISS) begin
					iss_q <= cfg_data; snxt_q <= cfg_data;
				end else begin
					adv_q <= cfg_data[15:0];
				end
			end
			case (sq_q)
				S_IDLE: if (start) sq_q <= S_DECIDE;
				S_DECIDE: begin
					cs_q <= n_cs; snxt_q <= n_snxt; suna_q <= n_suna;
					wus_q <= n_wus; wua_q <= n_wua; rnxt_q <= n_rnxt;
					fin_q <= df; dn_q <= '0;
					k_q <= AW'(cnt_q - CW'(1));
					if (dd) begin
						if (cnt_q == CW'(REORDER_DEPTH)) sq_q <= S_DLV_REQ;
						else if (cnt_q == '0) sq_q <= S_INS_NEW;
						else sq_q <= S_INS_CMP;
					end else if (df) begin
						sq_q <= S_FIN;
					end else begin
						sq_q <= S_IDLE;
					end
				end
				S_INS_CMP: begin
					if (c_lt) begin
						if (k_q == '0) sq_q <= S_INS_NEW;
						else k_q <= k_q - AW'(1);
					end else begin
						cnt_q <= cnt_q + CW'(1); sq_q <= S_DLV_REQ;
					end
				end
				S_INS_NEW: begin
					cnt_q <= cnt_q + CW'(1); sq_q <= S_DLV_REQ;
				end
				S_DLV_REQ: begin
					if (cnt_q == '0 || dn_q == 4'(MaxDeliver)) sq_q <= S_ACK;
					else sq_q <= S_DLV_CMP;
				end
				S_DLV_CMP: begin
					if (c_eq) begin
						rnxt_q <= rnxt_q + {16'd0, rdata.len};
						head_q <= ring(head_q, AW'(1));
						cnt_q <= cnt_q - CW'(1);
						dn_q <= dn_q + 4'd1;
						sq_q <= S_DLV_REQ;
					end else begin
						sq_q <= S_ACK;
					end
				end
				S_ACK: sq_q <= fin_q ? S_FIN : S_IDLE;
				S_FIN: begin
					rnxt_q <= seq_q + 32'd1; sq_q <= S_IDLE;
				end
				default: sq_q <= S_IDLE;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			fn_q <= func; fl_q <= seg_flags; seq_q <= seg_seq; ack_q <= seg_ack;
			win_q <= seg_window; len_q <= payload_length;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= e_v;
		end
	end

	always_ff @(posedge clk) begin
		if (e_v) begin
			kind <= e_kind; out_seq <= e_seq; out_ack <= e_ack;
			out_flags <= e_flags; out_length <= e_len; last <= e_last;
			out_window <= (e_kind == KIND_HDR) ? adv_q : 16'd0;
			conn_state_now <= (sq_q == S_DECIDE) ? n_cs : cs_q;
		end
	end

	// peer window is tracked by the update markers only
	logic unused_win;
	assign unused_win = ^win_q;

endmodule
